@@ rtl/sct_pkg.sv @@
// Socket table package: sizes, opcodes, states, types, init values, status codes
// No dependencies.
`timescale 1ns / 1ps
package sct_pkg;
	localparam int ENTRIES = 8;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [2:0] OP_OPEN = 3'd0;
	localparam logic [2:0] OP_BIND = 3'd1;
	localparam logic [2:0] OP_CONNECT = 3'd2;
	localparam logic [2:0] OP_LISTEN = 3'd3;
	localparam logic [2:0] OP_CLOSE = 3'd4;
	localparam logic [2:0] OP_LOOKUP = 3'd5;
	localparam logic [2:0] OP_SETST = 3'd6;

	localparam logic [2:0] ST_CLOSED = 3'd0;
	localparam logic [2:0] ST_LISTEN = 3'd1;
	localparam logic [2:0] ST_SYNSENT = 3'd2;
	localparam logic [2:0] ST_ESTAB = 3'd3;
	localparam logic [2:0] ST_CLOSEWAIT = 3'd4;
	localparam logic [2:0] ST_FINWAIT1 = 3'd5;
	localparam logic [2:0] ST_UDPCONN = 3'd6;

	localparam logic [3:0] TY_TCP_CLIENT = 4'd4;
	localparam logic [3:0] TY_TCP_SERVER = 4'd8;

	localparam logic [7:0] INIT_TTL = 8'd128;
	localparam logic [31:0] INIT_SEQ = 32'h1200;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_BADH = 3'd1;
	localparam logic [2:0] STS_E2 = 3'd2;
	localparam logic [2:0] STS_E3 = 3'd3;
	localparam logic [2:0] STS_E4 = 3'd4;
	localparam logic [2:0] STS_E5 = 3'd5;
	localparam logic [2:0] STS_E6 = 3'd6;
endpackage

@@ rtl/socket_connection_table_top.sv @@
// Socket connection table top level: entry storage, scan sequencer, opcode logic.
// Depends on sct_pkg.
`timescale 1ns / 1ps
// channel  | ports                                              | handshake
// input    | opcode protocol handle local_port remote_ip ...    | start & !busy
// result   | status result_handle found fin_request             | done, one cycle
// config   | reserved_port_data                                 | reserved_port_we
// Open, bind and lookup scan one entry a cycle with a shared compare unit, then
// execute. Other opcodes go straight from latch to execute.
// Reset clears all entries in flip-flops at once. The receiver cannot stall;
// done is pulsed one cycle and busy is high from accept until then.
module socket_connection_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  protocol,
	input  logic [7:0]  handle,
	input  logic [15:0] local_port,
	input  logic [31:0] remote_ip,
	input  logic [15:0] remote_port,
	input  logic        send_ok,
	input  logic [2:0]  new_state,
	input  logic        reserved_port_we,
	input  logic [15:0] reserved_port_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  result_handle,
	output logic        found,
	output logic        fin_request
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;
	localparam int IW = sct_pkg::IDX_W;
	localparam int CW = sct_pkg::CNT_W;

	state_t state_q;
	logic [2:0] op_q;
	logic [3:0] proto_q;
	logic [7:0] h_q;
	logic [15:0] lport_q, rport_q;
	logic [31:0] rip_q;
	logic sendok_q;
	logic [2:0] nst_q;
	logic [CW-1:0] cnt_q;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [15:0] resv_q;

	logic [sct_pkg::ENTRIES-1:0] used_q;
	logic [3:0] type_q [sct_pkg::ENTRIES];
	logic [2:0] est_q [sct_pkg::ENTRIES];
	logic [15:0] lp_q [sct_pkg::ENTRIES];
	logic [31:0] ip_q [sct_pkg::ENTRIES];
	logic [15:0] rp_q [sct_pkg::ENTRIES];
	logic [7:0] ttl_q [sct_pkg::ENTRIES];
	logic [31:0] seq_q [sct_pkg::ENTRIES];
	logic [31:0] ack_q [sct_pkg::ENTRIES];

	// shared per-entry compare unit
	logic [IW-1:0] ci;
	logic [15:0] cport;
	logic cmatch;
	always_comb begin
		ci = cnt_q[IW-1:0];
		cport = (ci == '0) ? resv_q : lp_q[ci];
		cmatch = 1'b0;
		case (op_q)
			sct_pkg::OP_OPEN: cmatch = (ci != '0) && !used_q[ci];
			sct_pkg::OP_LOOKUP: cmatch = (ci != '0) && (lp_q[ci] == lport_q)
				&& ((type_q[ci] & proto_q) != 4'd0);
			sct_pkg::OP_BIND: cmatch = (cport == lport_q)
				&& ({{(8-IW){1'b0}}, ci} != h_q);
			default: cmatch = 1'b0;
		endcase
	end

	logic hok, onehot;
	logic [IW-1:0] hi;
	assign hok = (h_q != 8'd0) && ({24'd0, h_q} < sct_pkg::ENTRIES);
	assign hi = h_q[IW-1:0];
	assign onehot = (proto_q == 4'd1) || (proto_q == 4'd2) || (proto_q == 4'd4)
		|| (proto_q == 4'd8);
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			status <= '0;
			result_handle <= '0;
			found <= 1'b0;
			fin_request <= 1'b0;
			resv_q <= '0;
			used_q <= '0;
			cnt_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			for (int i = 0; i < sct_pkg::ENTRIES; i++) begin
				type_q[i] <= '0; est_q[i] <= sct_pkg::ST_CLOSED; lp_q[i] <= '0;
				ip_q[i] <= '0; rp_q[i] <= '0; ttl_q[i] <= '0;
				seq_q[i] <= '0; ack_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			if (reserved_port_we) resv_q <= reserved_port_data;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= opcode; proto_q <= protocol; h_q <= handle;
						lport_q <= local_port; rip_q <= remote_ip;
						rport_q <= remote_port; sendok_q <= send_ok;
						nst_q <= new_state;
						cnt_q <= '0; hit_q <= 1'b0; hit_idx_q <= '0;
						state_q <= (opcode == sct_pkg::OP_OPEN || opcode == sct_pkg::OP_BIND
							|| opcode == sct_pkg::OP_LOOKUP) ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					if (cmatch && !hit_q) begin
						hit_q <= 1'b1; hit_idx_q <= ci;
					end
					if (cnt_q == CW'(sct_pkg::ENTRIES - 1)) state_q <= S_EXEC;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					status <= sct_pkg::STS_OK;
					result_handle <= '0;
					found <= 1'b0;
					fin_request <= 1'b0;
					case (op_q)
						sct_pkg::OP_OPEN: begin
							if (onehot && hit_q) begin
								used_q[hit_idx_q] <= 1'b1;
								type_q[hit_idx_q] <= proto_q;
								est_q[hit_idx_q] <= sct_pkg::ST_CLOSED;
								lp_q[hit_idx_q] <= '0; ip_q[hit_idx_q] <= '0;
								rp_q[hit_idx_q] <= '0; ttl_q[hit_idx_q] <= '0;
								seq_q[hit_idx_q] <= '0; ack_q[hit_idx_q] <= '0;
								result_handle <= 8'(hit_idx_q);
							end
						end
						sct_pkg::OP_LOOKUP: begin
							found <= hit_q;
							result_handle <= hit_q ? 8'(hit_idx_q) : 8'd0;
						end
						sct_pkg::OP_BIND, sct_pkg::OP_CONNECT, sct_pkg::OP_LISTEN,
						sct_pkg::OP_CLOSE, sct_pkg::OP_SETST: begin
							if (!hok) status <= sct_pkg::STS_BADH;
							else if (op_q == sct_pkg::OP_BIND) begin
								if (hit_q) status <= sct_pkg::STS_E2;
								else lp_q[hi] <= lport_q;
							end else if (!used_q[hi]) status <= sct_pkg::STS_E2;
							else if (op_q == sct_pkg::OP_CONNECT) begin
								if (est_q[hi] != sct_pkg::ST_CLOSED) status <= sct_pkg::STS_E3;
								else begin
									ip_q[hi] <= rip_q; rp_q[hi] <= rport_q;
									if (type_q[hi] == sct_pkg::TY_TCP_SERVER)
										status <= sct_pkg::STS_E4;
									else if (type_q[hi] == sct_pkg::TY_TCP_CLIENT) begin
										ttl_q[hi] <= sct_pkg::INIT_TTL;
										seq_q[hi] <= sct_pkg::INIT_SEQ;
										ack_q[hi] <= '0;
										est_q[hi] <= sct_pkg::ST_SYNSENT;
									end else est_q[hi] <= sct_pkg::ST_UDPCONN;
								end
							end else if (op_q == sct_pkg::OP_LISTEN) begin
								if (type_q[hi] != sct_pkg::TY_TCP_SERVER)
									status <= sct_pkg::STS_E3;
								else if (est_q[hi] != sct_pkg::ST_CLOSED)
									status <= sct_pkg::STS_E4;
								else begin
									ttl_q[hi] <= sct_pkg::INIT_TTL;
									seq_q[hi] <= sct_pkg::INIT_SEQ;
									ack_q[hi] <= '0;
									est_q[hi] <= sct_pkg::ST_LISTEN;
								end
							end else if (op_q == sct_pkg::OP_CLOSE) begin
								if (type_q[hi] == sct_pkg::TY_TCP_SERVER) begin
									if (est_q[hi] != sct_pkg::ST_ESTAB
										&& est_q[hi] != sct_pkg::ST_LISTEN)
										status <= sct_pkg::STS_E3;
									else begin
										fin_request <= 1'b1;
										if (sendok_q) est_q[hi] <= sct_pkg::ST_CLOSEWAIT;
										else status <= sct_pkg::STS_E4;
									end
								end else if (type_q[hi] == sct_pkg::TY_TCP_CLIENT) begin
									if (est_q[hi] != sct_pkg::ST_ESTAB)
										status <= sct_pkg::STS_E5;
									else begin
										fin_request <= 1'b1;
										if (sendok_q) est_q[hi] <= sct_pkg::ST_FINWAIT1;
										else status <= sct_pkg::STS_E6;
									end
								end else est_q[hi] <= sct_pkg::ST_CLOSED;
							end else est_q[hi] <= nst_q;
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sv/socket_connection_table_top_tb.sv @@
// Testbench for socket_connection_table_top: directed and random socket calls,
// checked against a behavioral model of the connection table kept here.
// Depends on sct_pkg and the RTL top level.
`timescale 1ns / 1ps
module socket_connection_table_top_tb;
	localparam int TIMEOUT_CYCLES = 20000;
	localparam int NUM_RANDOM = 630;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  result_handle;
		logic        found;
		logic        fin_request;
	} sock_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0]  opcode = '0;
	logic [3:0]  protocol = '0;
	logic [7:0]  handle = '0;
	logic [15:0] local_port = '0;
	logic [31:0] remote_ip = '0;
	logic [15:0] remote_port = '0;
	logic        send_ok = 1'b0;
	logic [2:0]  new_state = '0;
	logic        reserved_port_we = 1'b0;
	logic [15:0] reserved_port_data = '0;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  result_handle;
	logic        found;
	logic        fin_request;

	socket_connection_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .protocol(protocol), .handle(handle),
		.local_port(local_port), .remote_ip(remote_ip), .remote_port(remote_port),
		.send_ok(send_ok), .new_state(new_state),
		.reserved_port_we(reserved_port_we), .reserved_port_data(reserved_port_data),
		.done(done), .status(status), .result_handle(result_handle),
		.found(found), .fin_request(fin_request)
	);

	always #1 clk = ~clk;

	// model of the table
	logic [15:0] mdl_resv_port;
	logic        mdl_used [sct_pkg::ENTRIES];
	logic [3:0]  mdl_type [sct_pkg::ENTRIES];
	logic [2:0]  mdl_state [sct_pkg::ENTRIES];
	logic [15:0] mdl_lport [sct_pkg::ENTRIES];

	sock_result_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;

	function automatic void clear_table();
		for (int i = 0; i < sct_pkg::ENTRIES; i++) begin
			mdl_used[i] = 1'b0;
			mdl_type[i] = '0;
			mdl_state[i] = sct_pkg::ST_CLOSED;
			mdl_lport[i] = '0;
		end
	endfunction

	// remote address, ttl, seq, ack never reach an output, so they are not modeled
	function automatic sock_result_t table_op(logic [2:0] op, logic [3:0] proto,
			logic [7:0] h, logic [15:0] lport, logic sok, logic [2:0] nst);
		sock_result_t r;
		logic [15:0] p;
		r = '0;
		if (op == sct_pkg::OP_OPEN) begin
			if (proto == 4'd1 || proto == 4'd2 || proto == 4'd4 || proto == 4'd8) begin
				for (int i = 1; i < sct_pkg::ENTRIES; i++) begin
					if (!mdl_used[i]) begin
						mdl_used[i] = 1'b1;
						mdl_type[i] = proto;
						mdl_state[i] = sct_pkg::ST_CLOSED;
						mdl_lport[i] = '0;
						r.result_handle = 8'(i);
						break;
					end
				end
			end
		end else if (op == sct_pkg::OP_LOOKUP) begin
			for (int i = 1; i < sct_pkg::ENTRIES; i++) begin
				if (mdl_lport[i] == lport && (mdl_type[i] & proto) != 0) begin
					r.result_handle = 8'(i);
					r.found = 1'b1;
					break;
				end
			end
		end else if (op == 3'd7) begin
		end else if (h == 0 || h >= sct_pkg::ENTRIES) begin
			r.status = sct_pkg::STS_BADH;
		end else if (op == sct_pkg::OP_BIND) begin
			for (int i = 0; i < sct_pkg::ENTRIES; i++) begin
				p = (i == 0) ? mdl_resv_port : mdl_lport[i];
				if (p == lport && i != h) begin
					r.status = sct_pkg::STS_E2;
					break;
				end
			end
			if (r.status == sct_pkg::STS_OK)
				mdl_lport[h] = lport;
		end else if (!mdl_used[h]) begin
			r.status = sct_pkg::STS_E2;
		end else if (op == sct_pkg::OP_CONNECT) begin
			if (mdl_state[h] != sct_pkg::ST_CLOSED)
				r.status = sct_pkg::STS_E3;
			else if (mdl_type[h] == sct_pkg::TY_TCP_SERVER)
				r.status = sct_pkg::STS_E4;
			else if (mdl_type[h] == sct_pkg::TY_TCP_CLIENT)
				mdl_state[h] = sct_pkg::ST_SYNSENT;
			else
				mdl_state[h] = sct_pkg::ST_UDPCONN;
		end else if (op == sct_pkg::OP_LISTEN) begin
			if (mdl_type[h] != sct_pkg::TY_TCP_SERVER)
				r.status = sct_pkg::STS_E3;
			else if (mdl_state[h] != sct_pkg::ST_CLOSED)
				r.status = sct_pkg::STS_E4;
			else
				mdl_state[h] = sct_pkg::ST_LISTEN;
		end else if (op == sct_pkg::OP_CLOSE) begin
			if (mdl_type[h] == sct_pkg::TY_TCP_SERVER) begin
				if (mdl_state[h] != sct_pkg::ST_ESTAB
					&& mdl_state[h] != sct_pkg::ST_LISTEN) begin
					r.status = sct_pkg::STS_E3;
				end else begin
					r.fin_request = 1'b1;
					if (sok) mdl_state[h] = sct_pkg::ST_CLOSEWAIT;
					else r.status = sct_pkg::STS_E4;
				end
			end else if (mdl_type[h] == sct_pkg::TY_TCP_CLIENT) begin
				if (mdl_state[h] != sct_pkg::ST_ESTAB) begin
					r.status = sct_pkg::STS_E5;
				end else begin
					r.fin_request = 1'b1;
					if (sok) mdl_state[h] = sct_pkg::ST_FINWAIT1;
					else r.status = sct_pkg::STS_E6;
				end
			end else begin
				mdl_state[h] = sct_pkg::ST_CLOSED;
			end
		end else begin
			mdl_state[h] = nst;
		end
		return r;
	endfunction

	// at least one falling edge with start low; the block is busy then anyway
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n + 1) @(negedge clk);
	endtask

	// drive one item at the falling edge, hold until accepted
	task automatic send_item(logic [2:0] op, logic [3:0] proto, logic [7:0] h,
			logic [15:0] lport, logic [31:0] rip, logic [15:0] rport,
			logic sok, logic [2:0] nst);
		opcode <= op; protocol <= proto; handle <= h; local_port <= lport;
		remote_ip <= rip; remote_port <= rport; send_ok <= sok; new_state <= nst;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(table_op(op, proto, h, lport, sok, nst));
		@(negedge clk);
		start <= 1'b0;
		idle_gap();
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (sct_pkg::ENTRIES + 4) @(negedge clk);
	endtask

	task automatic write_reserved_port(logic [15:0] v);
		reserved_port_we <= 1'b1;
		reserved_port_data <= v;
		@(negedge clk);
		reserved_port_we <= 1'b0;
		mdl_resv_port = v;
	endtask

	// result checker
	always @(posedge clk) begin
		sock_result_t e;
		if (done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result status=%0d handle=%0d", status, result_handle);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status); errors++;
				end
				if (result_handle !== e.result_handle) begin
					$error("result_handle exp %0d got %0d", e.result_handle, result_handle);
					errors++;
				end
				if (found !== e.found) begin
					$error("found exp %0d got %0d", e.found, found); errors++;
				end
				if (fin_request !== e.fin_request) begin
					$error("fin_request exp %0d got %0d", e.fin_request, fin_request);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no accept and no result
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > TIMEOUT_CYCLES) begin
			$display("FAIL socket_connection_table_top");
			$finish;
		end
	end

	function automatic logic [3:0] rand_type();
		return 4'd1 << $urandom_range(0, 3);
	endfunction

	task automatic test_directed();
		write_reserved_port(16'hFFFF);
		send_item(sct_pkg::OP_OPEN, 4'd3, 0, 0, 0, 0, 0, 0);          // not one-hot
		send_item(sct_pkg::OP_OPEN, 4'd4, 0, 0, 0, 0, 0, 0);          // tcp client -> 1
		send_item(sct_pkg::OP_OPEN, 4'd8, 0, 0, 0, 0, 0, 0);          // tcp server -> 2
		send_item(sct_pkg::OP_OPEN, 4'd1, 0, 0, 0, 0, 0, 0);
		send_item(sct_pkg::OP_OPEN, 4'd2, 0, 0, 0, 0, 0, 0);
		send_item(sct_pkg::OP_BIND, 0, 8'd1, 16'hFFFF, 0, 0, 0, 0);   // clash with reserved
		send_item(sct_pkg::OP_BIND, 0, 8'd1, 16'd0, 0, 0, 0, 0);      // clash with unused
		send_item(sct_pkg::OP_BIND, 0, 8'd1, 16'd80, 0, 0, 0, 0);
		send_item(sct_pkg::OP_BIND, 0, 8'd2, 16'd80, 0, 0, 0, 0);
		send_item(sct_pkg::OP_BIND, 0, 8'd0, 16'd81, 0, 0, 0, 0);     // bad handle
		send_item(sct_pkg::OP_BIND, 0, 8'd255, 16'd81, 0, 0, 0, 0);
		send_item(sct_pkg::OP_CONNECT, 0, 8'd1, 0, 32'hFFFFFFFF, 16'hFFFF, 0, 0);
		send_item(sct_pkg::OP_CONNECT, 0, 8'd1, 0, 0, 0, 0, 0);       // not closed
		send_item(sct_pkg::OP_CONNECT, 0, 8'd2, 0, 0, 0, 0, 0);       // tcp server
		send_item(sct_pkg::OP_CONNECT, 0, 8'd3, 0, 32'h1, 16'h1, 0, 0);
		send_item(sct_pkg::OP_CONNECT, 0, 8'd7, 0, 0, 0, 0, 0);       // unused
		send_item(sct_pkg::OP_LISTEN, 0, 8'd2, 0, 0, 0, 0, 0);
		send_item(sct_pkg::OP_LISTEN, 0, 8'd2, 0, 0, 0, 0, 0);
		send_item(sct_pkg::OP_LISTEN, 0, 8'd1, 0, 0, 0, 0, 0);
		send_item(sct_pkg::OP_CLOSE, 0, 8'd2, 0, 0, 0, 1'b0, 0);
		send_item(sct_pkg::OP_CLOSE, 0, 8'd1, 0, 0, 0, 1'b1, 0);
		send_item(sct_pkg::OP_SETST, 0, 8'd1, 0, 0, 0, 0, sct_pkg::ST_ESTAB);
		send_item(sct_pkg::OP_CLOSE, 0, 8'd1, 0, 0, 0, 1'b0, 0);
		send_item(sct_pkg::OP_CLOSE, 0, 8'd1, 0, 0, 0, 1'b1, 0);
		send_item(sct_pkg::OP_LOOKUP, 4'hF, 0, 16'd80, 0, 0, 0, 0);
		send_item(3'd7, 4'hF, 8'd1, 16'hFFFF, 0, 0, 1'b1, 3'd7);
		wait_drained();
	endtask

	// mostly valid handles and small port set so binds and lookups hit
	task automatic test_random(int n);
		logic [2:0] op;
		logic [7:0] h;
		logic [15:0] p;
		for (int k = 0; k < n; k++) begin
			op = 3'($urandom_range(0, 7));
			h = ($urandom_range(0, 9) == 0) ? 8'($urandom)
				: 8'($urandom_range(1, sct_pkg::ENTRIES - 1));
			p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
			if (op == sct_pkg::OP_CLOSE && $urandom_range(0, 1)) begin
				send_item(sct_pkg::OP_SETST, 0, h, 0, 0, 0, 0,
					$urandom_range(0, 1) ? sct_pkg::ST_ESTAB : 3'($urandom));
			end
			send_item(op, ($urandom_range(0, 2) == 0) ? 4'($urandom) : rand_type(), h, p,
				$urandom, 16'($urandom), 1'($urandom), 3'($urandom));
			// return sockets to the closed state now and then; used entries are never freed
			if ($urandom_range(0, 5) == 0) begin
				send_item(sct_pkg::OP_SETST, 0, h, 0, 0, 0, 0, sct_pkg::ST_CLOSED);
				send_item(sct_pkg::OP_CLOSE, 4'd1, h, 0, 0, 0, 1'b1, 0);
			end
			if (k == n / 2) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		clear_table();
		mdl_resv_port = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		write_reserved_port(16'd0);
		test_random(NUM_RANDOM / 3);
		write_reserved_port(16'd3);
		test_random(NUM_RANDOM / 3);
		write_reserved_port(16'($urandom));
		test_random(NUM_RANDOM / 3);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS socket_connection_table_top");
		else
			$display("FAIL socket_connection_table_top");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/sct_pkg.sv
rtl/socket_connection_table_top.sv
tb/sv/socket_connection_table_top_tb.sv
